// ----- rtl/assert_macros.svh -----
// Assertion helpers used by ovl_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on a clock, disabled while reset is asserted (active low).
`define OVL_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ovl assertion failed");

// A signal holds its value in the cycle after cond.
`define OVL_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error("ovl hold assertion failed");

`endif

// ----- rtl/ovl_pkg.sv -----
package ovl_pkg;

  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 2'd0,
    CMD_INS_BACK  = 2'd1,
    CMD_DELETE    = 2'd2,
    CMD_SEARCH    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } state_e;

  typedef struct packed {
    cmd_e             op;
    logic [VAL_W-1:0] value;
    logic             cmp_en;
    logic             apply_en;
    logic             full;
    logic             found;
  } cell_ctl_t;

endpackage

// ----- rtl/ovl_cell.sv -----
module ovl_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ovl_pkg::cell_ctl_t       ctl_i,
  input  logic                     below_i,
  input  logic                     tail_i,
  input  logic [ovl_pkg::VAL_W-1:0] prev_entry_i,
  input  logic [ovl_pkg::VAL_W-1:0] next_entry_i,
  input  logic                     prefix_i,
  output logic [ovl_pkg::VAL_W-1:0] entry_o,
  output logic                     prefix_o
);
  import ovl_pkg::*;

  logic [VAL_W-1:0] entry_q, entry_d;
  logic             hit_q, hit_d;

  always_comb begin
    entry_d = entry_q;
    hit_d   = hit_q;
    if (ctl_i.cmp_en) begin
      hit_d = below_i && (entry_q == ctl_i.value);
    end
    if (ctl_i.apply_en) begin
      case (ctl_i.op)
        CMD_INS_FRONT: begin
          if (!ctl_i.full) entry_d = prev_entry_i;
        end
        CMD_INS_BACK: begin
          if (!ctl_i.full && tail_i) entry_d = ctl_i.value;
        end
        CMD_DELETE: begin
          // this cell and everything behind the first match close the gap
          if (ctl_i.found && (prefix_i || hit_q)) entry_d = next_entry_i;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign entry_o  = entry_q;
  assign prefix_o = prefix_i | hit_q;

endmodule

// ----- rtl/ordered_value_list_core.sv -----
// Ordered list of up to CAPACITY signed 32-bit values, front at position 0.
// Commands: insert front, insert back, delete first match, search; each request
// returns one result with success, entry count (low 5 bits) and an empty flag.
// Inserts into a full list are refused with success 0. A request goes through
// accept, compare in every cell and apply the shift, and one request is in work at
// a time; the registered per-cell match bits and the first-match chain along the
// cells set these steps. The result sits in an output register, so the next
// request is accepted while the previous result is still stalled.
module ordered_value_list_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ovl_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic signed [ovl_pkg::VAL_W-1:0] in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          out_success_o,
  output logic [ovl_pkg::CNT_OUT_W-1:0] out_entry_count_o,
  output logic                          out_list_empty_o
);
  import ovl_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  state_e             state_q, state_d;
  cmd_e               cmd_q;
  logic [VAL_W-1:0]   value_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q, out_valid_d;
  logic               success_q;
  logic [CNT_OUT_W-1:0] ocount_q;
  logic               oempty_q;

  logic               accept;
  logic               cmp_en, apply_en;
  logic               full, found, ok;
  cell_ctl_t          ctl;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;

  logic [VAL_W-1:0]   entry [CAPACITY];
  logic [CAPACITY:0]  prefix;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CNT_W'(CAPACITY));
  assign found      = prefix[CAPACITY];
  assign prefix[0]  = 1'b0;

  always_comb begin
    state_d     = state_q;
    cmp_en      = 1'b0;
    apply_en    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CMP;
      end
      ST_CMP: begin
        cmp_en  = 1'b1;
        state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (!out_valid_q || !out_stall_i) begin
          apply_en    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d = count_q;
    ok      = 1'b0;
    case (cmd_q)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        ok = !full;
        if (!full) count_d = count_q + CNT_W'(1);
      end
      CMD_DELETE: begin
        ok = found;
        if (found) count_d = count_q - CNT_W'(1);
      end
      default: ok = found;
    endcase
  end

  assign cnt_wide = {{CNT_OUT_W{1'b0}}, count_d};

  assign ctl.op       = cmd_q;
  assign ctl.value    = value_q;
  assign ctl.cmp_en   = cmp_en;
  assign ctl.apply_en = apply_en;
  assign ctl.full     = full;
  assign ctl.found    = found;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] prev_entry, next_entry;
    if (g == 0) begin : g_head
      assign prev_entry = value_q;
    end else begin : g_mid
      assign prev_entry = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_entry = entry[g];
    end else begin : g_inner
      assign next_entry = entry[g+1];
    end
    ovl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .below_i      (CNT_W'(g) < count_q),
      .tail_i       (CNT_W'(g) == count_q),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .prefix_i     (prefix[g]),
      .entry_o      (entry[g]),
      .prefix_o     (prefix[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (apply_en) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(in_cmd_i);
      value_q <= in_value_i;
    end
    if (apply_en) begin
      success_q <= ok;
      ocount_q  <= cnt_wide[CNT_OUT_W-1:0];
      oempty_q  <= (count_d == '0);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_success_o     = success_q;
  assign out_entry_count_o = ocount_q;
  assign out_list_empty_o  = oempty_q;

endmodule

// ----- rtl/ovl_checker.sv -----
`include "assert_macros.svh"

module ovl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          out_success_o,
  input logic [ovl_pkg::CNT_OUT_W-1:0] out_entry_count_o,
  input logic                          out_list_empty_o
);

  `OVL_ASSERT(a_empty_count, clk_i, rst_ni, (out_valid_o && out_list_empty_o) |-> (out_entry_count_o == '0))
  `OVL_ASSERT(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `OVL_ASSERT(a_result_from_busy, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))
  `OVL_ASSERT_HOLD(a_result_hold, clk_i, rst_ni, out_valid_o && out_stall_i, {out_valid_o, out_success_o, out_entry_count_o, out_list_empty_o})

endmodule

bind ordered_value_list_core ovl_checker u_ovl_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .out_success_o     (out_success_o),
  .out_entry_count_o (out_entry_count_o),
  .out_list_empty_o  (out_list_empty_o)
);

// ----- tb/tb.sv -----
module tb;
  import ovl_pkg::*;

  localparam int unsigned LIST_CAP = 16;
  localparam int          DIR_ROWS_N = 25;
  localparam int          PHASE_ITEMS = 150;

  typedef struct packed {
    logic                 success;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 list_empty;
  } list_result_t;

  typedef struct packed {
    cmd_e             op;
    logic [VAL_W-1:0] value;
    logic             typed;
    list_result_t     want;
  } dir_row_t;

  localparam list_result_t NO_RES = '0;

  // typed rows carry the result; the rest go through the list predictor
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    '{CMD_SEARCH,    32'h0000_0000, 1'b1, '{1'b0, 5'd0, 1'b1}},
    '{CMD_DELETE,    32'h0000_0000, 1'b1, '{1'b0, 5'd0, 1'b1}},
    '{CMD_INS_FRONT, 32'h8000_0000, 1'b1, '{1'b1, 5'd1, 1'b0}},
    '{CMD_INS_BACK,  32'h7FFF_FFFF, 1'b1, '{1'b1, 5'd2, 1'b0}},
    '{CMD_SEARCH,    32'h8000_0000, 1'b1, '{1'b1, 5'd2, 1'b0}},
    '{CMD_INS_BACK,  32'h0000_0005, 1'b1, '{1'b1, 5'd3, 1'b0}},
    '{CMD_INS_FRONT, 32'h0000_0005, 1'b1, '{1'b1, 5'd4, 1'b0}},
    '{CMD_INS_BACK,  32'hFFFF_FFFF, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'h0000_0000, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'h0000_0001, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'hAAAA_AAAA, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'hA5A5_A5A5, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'h5A5A_5A5A, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'h0001_0000, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'hFFFF_0000, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'h0000_FFFF, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'h4000_0000, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'hC000_0000, 1'b0, NO_RES},
    '{CMD_INS_BACK,  32'h0000_0003, 1'b0, NO_RES},
    '{CMD_INS_FRONT, 32'h1234_5678, 1'b1, '{1'b0, 5'd16, 1'b0}},
    '{CMD_INS_BACK,  32'h1234_5678, 1'b1, '{1'b0, 5'd16, 1'b0}},
    '{CMD_DELETE,    32'h0000_0005, 1'b0, NO_RES},
    '{CMD_SEARCH,    32'h0000_0005, 1'b0, NO_RES},
    '{CMD_DELETE,    32'h5555_5555, 1'b0, NO_RES},
    '{CMD_SEARCH,    32'h7FFF_FFFF, 1'b0, NO_RES}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     in_cmd_i;
  logic [VAL_W-1:0]     in_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 out_success_o;
  logic [CNT_OUT_W-1:0] out_entry_count_o;
  logic                 out_list_empty_o;

  logic [VAL_W-1:0] list_vals [LIST_CAP];
  int unsigned      list_len;
  list_result_t     pending_results [$];
  int               err_count;
  int               accepted_count;
  int               send_idle_pct;
  int               recv_stall_pct;
  logic             long_hold_done;

  ordered_value_list_core #(
    .CAPACITY (LIST_CAP)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_cmd_i          (in_cmd_i),
    .in_value_i        (in_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_success_o     (out_success_o),
    .out_entry_count_o (out_entry_count_o),
    .out_list_empty_o  (out_list_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic list_result_t apply_list_cmd(input cmd_e op, input logic [VAL_W-1:0] v);
    list_result_t r;
    int           pos;
    int           i;
    r.success = 1'b0;
    pos = -1;
    for (i = 0; i < int'(list_len); i++) begin
      if (pos < 0 && list_vals[i] == v) pos = i;
    end
    case (op)
      CMD_INS_FRONT: begin
        if (list_len < LIST_CAP) begin
          for (i = int'(list_len); i > 0; i--) list_vals[i] = list_vals[i-1];
          list_vals[0] = v;
          list_len++;
          r.success = 1'b1;
        end
      end
      CMD_INS_BACK: begin
        if (list_len < LIST_CAP) begin
          list_vals[list_len] = v;
          list_len++;
          r.success = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos >= 0) begin
          for (i = pos; i + 1 < int'(list_len); i++) list_vals[i] = list_vals[i+1];
          list_len--;
          r.success = 1'b1;
        end
      end
      default: r.success = (pos >= 0);
    endcase
    r.entry_count = list_len[CNT_OUT_W-1:0];
    r.list_empty  = (list_len == 0);
    return r;
  endfunction

  task automatic send_request(input cmd_e op, input logic [VAL_W-1:0] v, input logic typed,
                              input list_result_t want);
    list_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_cmd_i   <= op;
    in_value_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = apply_list_cmd(op, v);
    pending_results.push_back(typed ? want : r);
    accepted_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    list_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending", $time);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_success_o !== exp_r.success) begin
          $display("%0t: success expected %0d got %0d", $time, exp_r.success, out_success_o);
          err_count++;
        end
        if (out_entry_count_o !== exp_r.entry_count) begin
          $display("%0t: entry_count expected %0d got %0d", $time, exp_r.entry_count,
                   out_entry_count_o);
          err_count++;
        end
        if (out_list_empty_o !== exp_r.list_empty) begin
          $display("%0t: list_empty expected %0d got %0d", $time, exp_r.list_empty,
                   out_list_empty_o);
          err_count++;
        end
      end
    end
  end

  // result side stalls, with one long hold-off while the sender keeps going
  initial begin
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!long_hold_done && accepted_count >= 340) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (80) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int               k;
    int               ph;
    int               ins_pct;
    int               pick;
    cmd_e             op;
    logic [VAL_W-1:0] v;
    err_count      = 0;
    accepted_count = 0;
    list_len       = 0;
    long_hold_done = 1'b0;
    send_idle_pct  = 16;
    recv_stall_pct = 55;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_cmd_i   <= CMD_SEARCH;
    in_value_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < DIR_ROWS_N; k++) begin
      send_request(DIR_ROWS[k].op, DIR_ROWS[k].value, DIR_ROWS[k].typed, DIR_ROWS[k].want);
    end

    for (ph = 0; ph < 3; ph++) begin
      // drain before the idling pattern changes
      in_valid_i <= 1'b0;
      wait (pending_results.size() == 0);
      @(posedge clk_i);
      send_idle_pct  = (ph == 0) ? 16 : (ph == 1) ? 55 : 0;
      recv_stall_pct = (ph == 0) ? 55 : (ph == 1) ? 16 : 0;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // swing between filling and draining so both full and empty are reached
        ins_pct = ((k / 30) % 2 == 0) ? 75 : 25;
        if ($urandom_range(99) < ins_pct) begin
          op = $urandom_range(1) ? CMD_INS_BACK : CMD_INS_FRONT;
        end else begin
          op = $urandom_range(1) ? CMD_SEARCH : CMD_DELETE;
        end
        pick = $urandom_range(99);
        if (list_len > 0 && pick < 55) begin
          v = list_vals[$urandom_range(list_len - 1)];
        end else if (pick < 75) begin
          case ($urandom_range(3))
            0:       v = 32'h0000_0000;
            1:       v = 32'h8000_0000;
            2:       v = 32'h7FFF_FFFF;
            default: v = 32'hFFFF_FFFF;
          endcase
        end else begin
          v = $urandom();
        end
        send_request(op, v, 1'b0, NO_RES);
      end
    end

    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/ovl_pkg.sv
rtl/ovl_cell.sv
rtl/ordered_value_list_core.sv
rtl/ovl_checker.sv
tb/tb.sv
